// ===== design/fixed_variable_step_timer_core_defines.svh =====
// Assertion helpers for the step timer.
`ifndef FIXED_VARIABLE_STEP_TIMER_CORE_DEFINES_SVH
`define FIXED_VARIABLE_STEP_TIMER_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define FVST_CHECK(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define FVST_CHECK_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/fvst_pkg.sv =====
`timescale 1ns / 1ps
package fvst_pkg;

  localparam int MAX_UPDATES = 64;
  localparam int UPD_CNT_W   = $clog2(MAX_UPDATES + 1);

  localparam int ACC_W       = 33;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;
  localparam int WORK_W      = 12;

  localparam logic [CFG_IDX_W-1:0] REG_FIXED_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DELTA  = 2'd2;

  localparam logic [9:0]  ONE_SECOND    = 10'd1000;
  localparam logic [9:0]  MIN_TARGET    = 10'd16;
  localparam logic [9:0]  TARGET_RESET  = 10'd16;
  localparam logic [9:0]  MAX_DELTA_RST = 10'd1000;
  localparam logic [10:0] SNAP_SLACK    = 11'd3;
  localparam logic [10:0] LEFTOVER_MAX  = 11'd2047;
  localparam logic [15:0] RATE_MAX      = 16'hFFFF;

  typedef struct packed {
    logic       fixed_mode;
    logic [9:0] target_ms;
    logic [9:0] max_delta_ms;
  } cfg_t;

endpackage

// ===== design/fvst_cfg.sv =====
`timescale 1ns / 1ps
module fvst_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fvst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fvst_pkg::CFG_DATA_W-1:0] cfg_data,
  output fvst_pkg::cfg_t                cfg
);
  import fvst_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fixed_mode   <= 1'b0;
      cfg.target_ms    <= TARGET_RESET;
      cfg.max_delta_ms <= MAX_DELTA_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FIXED_MODE: cfg.fixed_mode   <= cfg_data[0];
        REG_TARGET:     cfg.target_ms    <= cfg_data;
        REG_MAX_DELTA:  cfg.max_delta_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/fvst_cmpsub.sv =====
`timescale 1ns / 1ps
module fvst_cmpsub (
  input  logic [fvst_pkg::WORK_W-1:0] a,
  input  logic [fvst_pkg::WORK_W-1:0] b,
  output logic [fvst_pkg::WORK_W-1:0] diff,
  output logic                        ge
);
  import fvst_pkg::*;

  logic borrow;

  // a - b with a borrow out; ge when no borrow
  assign {borrow, diff} = {1'b0, a} - {1'b0, b};
  assign ge = ~borrow;

endmodule

// ===== design/fixed_variable_step_timer_core.sv =====
// Channel   Direction  Handshake            Payload
// in        request    in_valid / in_stall   current_time_ms
// out       result     out_valid / out_stall elapsed_ms, total_ms, frame_number,
//                                             rate_per_second, last_update
// cfg       write      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Sequence: a request is captured, prepared, then runs the update loop (up to 64
//   updates in fixed mode, one in variable mode), then the rollover trim when the
//   one-second accumulator rolls over (fold by 1024 = 24 mod 1000, then trim by 1000
//   through the shared subtractor). One compare/subtract per cycle while not stalled.
// Reset: synchronous, clears all timer state; config returns to variable mode,
//   16 ms target, 1000 ms max delta.
// Stalls: in_stall is high whenever the sequencer is busy. out_stall holds the
//   output register; the loop keeps one pending update and waits for a free slot.
`timescale 1ns / 1ps
`include "fixed_variable_step_timer_core_defines.svh"
module fixed_variable_step_timer_core (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [31:0]                     current_time_ms,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [9:0]                      elapsed_ms,
  output logic [31:0]                     total_ms,
  output logic [31:0]                     frame_number,
  output logic [15:0]                     rate_per_second,
  output logic                            last_update,
  // config write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fvst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fvst_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fvst_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_EMIT, ST_MOD} state_t;

  state_t state;
  cfg_t   cfg;

  // timer state
  logic [31:0]          previous_time;
  logic [ACC_W-1:0]     second_acc;
  logic [10:0]          leftover;
  logic [31:0]          sim_total;
  logic [31:0]          update_count;
  logic [15:0]          count_sec;
  logic [15:0]          latched_rate;

  // per-request working registers
  logic [31:0]          raw_ms;
  logic [9:0]           target_eff;
  logic [WORK_W-1:0]    left;
  logic [UPD_CNT_W-1:0] upd_n;
  logic                 single;
  logic                 have_pend;
  logic [9:0]           pend_elapsed;
  logic [31:0]          pend_total;
  logic [31:0]          pend_frame;
  logic [15:0]          pend_rate;

  // shared unit
  logic [WORK_W-1:0]    unit_a;
  logic [WORK_W-1:0]    unit_b;
  logic [WORK_W-1:0]    unit_diff;
  logic                 unit_ge;

  logic [9:0]           delta_clamp;
  logic [9:0]           target_cfg;
  logic                 snap;
  logic [9:0]           delta_snap;
  logic [WORK_W-1:0]    left_init;
  logic                 slot_free;
  logic                 can_go;
  logic                 step;
  logic                 push;
  logic [10:0]          left_sat;
  logic [15:0]          cnt_after;
  logic                 acc_roll;
  logic                 fold_need;
  logic [ACC_W-1:0]     acc_fold;
  logic [31:0]          total_var;
  logic [31:0]          total_fix;

  fvst_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fvst_cmpsub u_unit (
    .a    (unit_a),
    .b    (unit_b),
    .diff (unit_diff),
    .ge   (unit_ge)
  );

  // Loop uses left - target; rollover trims the folded count by 1000.
  always_comb begin
    if (state == ST_MOD) begin
      unit_a = second_acc[WORK_W-1:0];
      unit_b = WORK_W'(ONE_SECOND);
    end else begin
      unit_a = left;
      unit_b = WORK_W'(target_eff);
    end
  end

  // 1024 = 24 mod 1000: high part times 24 (x16 + x8) plus the low 10 bits
  assign fold_need = |second_acc[ACC_W-1:11];
  assign acc_fold  = ACC_W'({second_acc[ACC_W-1:10], 4'b0000}) +
                     ACC_W'({second_acc[ACC_W-1:10], 3'b000}) +
                     ACC_W'(second_acc[9:0]);

  // Prep path: clamp, floor the target, snap within 3 ms, add leftover.
  assign delta_clamp = (raw_ms > 32'(cfg.max_delta_ms)) ? cfg.max_delta_ms : raw_ms[9:0];
  assign target_cfg  = (cfg.target_ms < MIN_TARGET) ? MIN_TARGET : cfg.target_ms;
  assign snap = (({1'b0, delta_clamp} + SNAP_SLACK) >= {1'b0, target_cfg}) &&
                ({1'b0, delta_clamp} <= ({1'b0, target_cfg} + SNAP_SLACK));
  assign delta_snap = snap ? target_cfg : delta_clamp;
  assign left_init  = WORK_W'(leftover) + WORK_W'(delta_snap);
  assign total_var  = sim_total + 32'(delta_clamp);
  assign total_fix  = sim_total + 32'(target_eff);

  // Loop control: one pending update is held until we know whether it is the last.
  assign slot_free = !out_valid || !out_stall;
  assign can_go    = !have_pend || slot_free;
  assign step      = !single && unit_ge && (upd_n < UPD_CNT_W'(MAX_UPDATES));
  assign push      = (state == ST_EMIT) && can_go && have_pend;

  assign left_sat  = (left > WORK_W'(LEFTOVER_MAX)) ? LEFTOVER_MAX : left[10:0];
  assign cnt_after = (upd_n == '0) ? count_sec :
                     ((count_sec != RATE_MAX) ? count_sec + 16'd1 : count_sec);
  assign acc_roll  = second_acc >= ACC_W'(ONE_SECOND);

  assign in_stall  = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      previous_time <= '0;
      second_acc    <= '0;
      leftover      <= '0;
      sim_total     <= '0;
      update_count  <= '0;
      count_sec     <= '0;
      latched_rate  <= '0;
      upd_n         <= '0;
      single        <= 1'b0;
      have_pend     <= 1'b0;
      out_valid     <= 1'b0;
      left          <= '0;
    end else begin
      // output register
      if (push) begin
        out_valid       <= 1'b1;
        elapsed_ms      <= pend_elapsed;
        total_ms        <= pend_total;
        frame_number    <= pend_frame;
        rate_per_second <= pend_rate;
        last_update     <= !step;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            raw_ms        <= current_time_ms - previous_time;
            previous_time <= current_time_ms;
            state         <= ST_PREP;
          end
        end

        ST_PREP: begin
          second_acc <= second_acc + ACC_W'(raw_ms);
          target_eff <= target_cfg;
          if (cfg.fixed_mode) begin
            left      <= left_init;
            upd_n     <= '0;
            have_pend <= 1'b0;
            single    <= 1'b0;
          end else begin
            // variable mode: the single update is pending right away
            left         <= '0;
            upd_n        <= UPD_CNT_W'(1);
            have_pend    <= 1'b1;
            single       <= 1'b1;
            pend_elapsed <= delta_clamp;
            pend_total   <= total_var;
            pend_frame   <= update_count + 32'd1;
            pend_rate    <= latched_rate;
            sim_total    <= total_var;
            update_count <= update_count + 32'd1;
          end
          state <= ST_EMIT;
        end

        ST_EMIT: begin
          if (can_go) begin
            if (step) begin
              have_pend    <= 1'b1;
              left         <= unit_diff;
              upd_n        <= upd_n + UPD_CNT_W'(1);
              pend_elapsed <= target_eff;
              pend_total   <= total_fix;
              pend_frame   <= update_count + 32'd1;
              pend_rate    <= latched_rate;
              sim_total    <= total_fix;
              update_count <= update_count + 32'd1;
            end else begin
              have_pend <= 1'b0;
              leftover  <= left_sat;
              if (acc_roll) begin
                latched_rate <= cnt_after;
                count_sec    <= '0;
                state        <= ST_MOD;
              end else begin
                count_sec <= cnt_after;
                state     <= ST_IDLE;
              end
            end
          end
        end

        ST_MOD: begin
          // fold while above 2047, then subtract 1000 until below it
          if (fold_need) begin
            second_acc <= acc_fold;
          end else if (unit_ge) begin
            second_acc <= ACC_W'(unit_diff);
          end else begin
            state <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  `FVST_CHECK(a_upd_bound, clk, rst, 1'b1, upd_n <= UPD_CNT_W'(MAX_UPDATES), "update count over limit")
  `FVST_CHECK(a_acc_range, clk, rst, state == ST_IDLE, second_acc < ACC_W'(ONE_SECOND), "second count out of range")
  `FVST_CHECK(a_idle_clean, clk, rst, state == ST_IDLE, !have_pend, "pending update left in idle")
  `FVST_CHECK_NEXT(a_last_ends, clk, rst, push && !step, state != ST_EMIT, "loop runs past last update")

endmodule
